// File: src/assert_macros.svh
// Assertion macros shared by the miss status holding table modules.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define MSHT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("miss status holding table: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define MSHT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("miss status holding table: assertion failed");
`else
`define MSHT_ASSERT_IMP(label, ante, cons)
`define MSHT_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: src/msht_pkg.sv
// Package with the types and constants of the miss status holding table.
`timescale 1ns / 1ps
package msht_pkg;

	localparam int ADDR_W   = 40;
	localparam int MODE_W   = 2;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 5;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT   = 2'd0,
		MODE_COMPLETE = 2'd1,
		MODE_RENAME   = 2'd2,
		MODE_UNUSED   = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_STORED         = 3'd0,
		ST_WB_PASSED      = 3'd1,
		ST_HELD           = 3'd2,
		ST_DROPPED        = 3'd3,
		ST_REMOVED        = 3'd4,
		ST_NOMATCH_REMOVE = 3'd5,
		ST_RENAMED        = 3'd6,
		ST_NOMATCH_RENAME = 3'd7
	} status_t;

	typedef enum logic {
		CTL_IDLE = 1'b0,
		CTL_EXEC = 1'b1
	} ctl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic execute;
	} cmd_t;

endpackage

// File: src/msht_req_if.sv
// Request channel interface: valid/ready handshake with the operation payload.
`timescale 1ns / 1ps
interface msht_req_if
	import msht_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [ADDR_W-1:0] address;
	logic [ADDR_W-1:0] new_address;
	logic              is_writeback;

	modport source (output valid, mode, address, new_address, is_writeback, input ready);
	modport sink (input valid, mode, address, new_address, is_writeback, output ready);
endinterface

// File: src/msht_rsp_if.sv
// Response channel interface: valid/ready handshake with the result payload.
`timescale 1ns / 1ps
interface msht_rsp_if
	import msht_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [OCC_W-1:0]    occupancy;
	logic                holding;
	logic                promoted;

	modport source (output valid, status, occupancy, holding, promoted, input ready);
	modport sink (input valid, status, occupancy, holding, promoted, output ready);
endinterface

// File: src/msht_ctrl.sv
// Controller state machine: request capture, execute sequencing and response valid.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msht_ctrl
	import msht_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	ctl_state_t state_q, state_d;
	logic       rsp_valid_q, rsp_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		case (state_q)
			CTL_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = CTL_EXEC;
				end
			end
			CTL_EXEC: begin
				// The result register must be free, or be emptied in this cycle.
				if (!rsp_valid_q || rsp_ready) begin
					cmd.execute = 1'b1;
					rsp_valid_d = 1'b1;
					state_d     = CTL_IDLE;
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	`MSHT_ASSERT_IMP(a_exec_room, cmd.execute, !rsp_valid_q || rsp_ready)
	`MSHT_ASSERT_NXT(a_capture_exec, cmd.capture, state_q == CTL_EXEC)
endmodule

// File: src/msht_dp.sv
// Datapath: operation registers, ordered entry table, hold slot and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module msht_dp
	import msht_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	input  logic [MODE_W-1:0]   mode,
	input  logic [ADDR_W-1:0]   address,
	input  logic [ADDR_W-1:0]   new_address,
	input  logic                is_writeback,
	output logic [STATUS_W-1:0] status,
	output logic [OCC_W-1:0]    occupancy,
	output logic                holding,
	output logic                promoted
);

	localparam int CW = $clog2(DEPTH + 1);

	// Captured request.
	logic [MODE_W-1:0] op_mode_q;
	logic [ADDR_W-1:0] op_addr_q;
	logic [ADDR_W-1:0] op_naddr_q;
	logic              op_wb_q;

	// Table and hold slot.
	logic [ADDR_W-1:0] entry_q [DEPTH];
	logic [CW-1:0]     count_q;
	logic              hold_valid_q;
	logic              hold_wb_q;
	logic [ADDR_W-1:0] hold_addr_q;

	// Result register.
	logic [STATUS_W-1:0] status_q;
	logic [OCC_W-1:0]    occ_q;
	logic                holding_q;
	logic                promoted_q;

	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] seen;
	logic [DEPTH-1:0] first;
	logic             hit;
	logic             full;

	status_t       status_d;
	logic [CW-1:0] count_d;
	logic [CW-1:0] count_rm;
	logic          hold_valid_d;
	logic          hold_wb_d;
	logic          hold_load;
	logic          promoted_d;
	logic          ins_store;
	logic          prom_store;
	logic          do_remove;
	logic          do_rename;
	logic [CW+OCC_W-1:0] occ_ext;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_mode_q  <= mode;
			op_addr_q  <= address;
			op_naddr_q <= new_address;
			op_wb_q    <= is_writeback;
		end
	end

	// Parallel compare, then a prefix OR picks the oldest match.
	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_match
			assign match[gi] = (CW'(gi) < count_q) && (entry_q[gi] == op_addr_q);
			if (gi == 0) begin : g_first
				assign seen[gi]  = match[gi];
				assign first[gi] = match[gi];
			end else begin : g_rest
				assign seen[gi]  = match[gi] | seen[gi-1];
				assign first[gi] = match[gi] & ~seen[gi-1];
			end
		end
	endgenerate

	assign hit      = seen[DEPTH-1];
	assign full     = (count_q == CW'(DEPTH));
	assign count_rm = count_q - CW'(hit);

	always_comb begin
		status_d     = ST_NOMATCH_RENAME;
		count_d      = count_q;
		hold_valid_d = hold_valid_q;
		hold_wb_d    = hold_wb_q;
		hold_load    = 1'b0;
		promoted_d   = 1'b0;
		ins_store    = 1'b0;
		prom_store   = 1'b0;
		do_remove    = 1'b0;
		do_rename    = 1'b0;
		case (mode_t'(op_mode_q))
			MODE_INSERT: begin
				if (hold_valid_q) begin
					status_d = ST_DROPPED;
				end else if (full) begin
					status_d     = ST_HELD;
					hold_load    = 1'b1;
					hold_valid_d = 1'b1;
					hold_wb_d    = op_wb_q;
				end else if (op_wb_q) begin
					status_d = ST_WB_PASSED;
				end else begin
					status_d  = ST_STORED;
					ins_store = 1'b1;
					count_d   = count_q + CW'(1);
				end
			end
			MODE_COMPLETE: begin
				do_remove = hit;
				status_d  = hit ? ST_REMOVED : ST_NOMATCH_REMOVE;
				count_d   = count_rm;
				// The held request is retried after a completion that leaves room in the table.
				if (hold_valid_q && (count_rm != CW'(DEPTH))) begin
					hold_valid_d = 1'b0;
					hold_wb_d    = 1'b0;
					if (!hold_wb_q) begin
						prom_store = 1'b1;
						promoted_d = 1'b1;
						count_d    = count_rm + CW'(1);
					end
				end
			end
			MODE_RENAME: begin
				do_rename = hit;
				status_d  = hit ? ST_RENAMED : ST_NOMATCH_RENAME;
			end
			default: begin
				status_d = ST_NOMATCH_RENAME;
			end
		endcase
	end

	// Each entry takes a new address, the rename value, the promoted address,
	// or, except the last, its younger neighbor when the gap behind a removed entry closes.
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_entry
			if (gi < DEPTH - 1) begin : g_shift
				always_ff @(posedge clk) begin
					if (cmd.execute) begin
						if (ins_store && (count_q == CW'(gi))) begin
							entry_q[gi] <= op_addr_q;
						end else if (do_rename && first[gi]) begin
							entry_q[gi] <= op_naddr_q;
						end else if (prom_store && (count_rm == CW'(gi))) begin
							entry_q[gi] <= hold_addr_q;
						end else if (do_remove && seen[gi] && (CW'(gi + 1) < count_q)) begin
							entry_q[gi] <= entry_q[gi+1];
						end
					end
				end
			end else begin : g_last
				always_ff @(posedge clk) begin
					if (cmd.execute) begin
						if (ins_store && (count_q == CW'(gi))) begin
							entry_q[gi] <= op_addr_q;
						end else if (do_rename && first[gi]) begin
							entry_q[gi] <= op_naddr_q;
						end else if (prom_store && (count_rm == CW'(gi))) begin
							entry_q[gi] <= hold_addr_q;
						end
					end
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			hold_valid_q <= 1'b0;
			hold_wb_q    <= 1'b0;
		end else if (cmd.execute) begin
			count_q      <= count_d;
			hold_valid_q <= hold_valid_d;
			hold_wb_q    <= hold_wb_d;
		end
	end

	assign occ_ext = {{OCC_W{1'b0}}, count_d};

	always_ff @(posedge clk) begin
		if (cmd.execute && hold_load) begin
			hold_addr_q <= op_addr_q;
		end
		if (cmd.execute) begin
			status_q   <= status_d;
			occ_q      <= occ_ext[OCC_W-1:0];
			holding_q  <= hold_valid_d;
			promoted_q <= promoted_d;
		end
	end

	assign status    = status_q;
	assign occupancy = occ_q;
	assign holding   = holding_q;
	assign promoted  = promoted_q;

	`MSHT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`MSHT_ASSERT_IMP(a_hold_when_full, $rose(hold_valid_q), count_q == CW'(DEPTH))
	`MSHT_ASSERT_IMP(a_one_match_pick, 1'b1, $onehot0(first))
endmodule

// File: src/miss_status_holding_table_top.sv
// Top level of the miss status holding table: controller, datapath and channel wiring.
`timescale 1ns / 1ps
// The block keeps an ordered table of up to TABLE_DEPTH outstanding miss
// addresses plus one hold slot. Each request on the req channel is an insert,
// a completion or a rename, and each request produces exactly one response
// on the rsp channel with a status code, the table occupancy after the
// request, the hold slot state and a flag that tells whether a held request
// entered the table. The cycle in which a request is accepted loads the
// operation registers; the execute state that follows compares the address
// against every valid entry in parallel, picks the oldest match with a
// priority chain, and applies the insert or hold, the compaction after a
// removal with any promotion of the held request, or the rename while it
// loads the response register. A new request is accepted in the cycle after
// execute, even while the previous response still waits on rsp; execute only
// waits when the response register is still full, and no new request is
// taken before the previous one has executed. The entry storage is flip-flops
// with no reset and no clearing pass; entries beyond the fill count are never
// read, so the block is ready for requests in the first cycle after reset.
module miss_status_holding_table_top
	import msht_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input logic         clk,
	input logic         arst_n,
	msht_req_if.sink    req,
	msht_rsp_if.source  rsp
);

	// Commands from the controller into the datapath.
	cmd_t cmd;

	// The controller owns the handshakes and decides when the datapath
	// captures a request and when it executes it.
	msht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	// The datapath holds the table, the hold slot and the response payload.
	msht_dp #(
		.DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (req.mode),
		.address      (req.address),
		.new_address  (req.new_address),
		.is_writeback (req.is_writeback),
		.status       (rsp.status),
		.occupancy    (rsp.occupancy),
		.holding      (rsp.holding),
		.promoted     (rsp.promoted)
	);

endmodule
